/* design/bftr_pkg.sv */
package bftr_pkg;

    localparam int SCREEN_WIDTH_DEF  = 480;
    localparam int SCREEN_HEIGHT_DEF = 320;
    localparam int GLYPH_WORDS_DEF   = 4096;
    localparam int CODE_SLOTS_DEF    = 256;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 9;

    localparam logic [2:0] REQ_BITMAP = 3'd0;
    localparam logic [2:0] REQ_WIDTH  = 3'd1;
    localparam logic [2:0] REQ_OFFSET = 3'd2;
    localparam logic [2:0] REQ_BEGIN  = 3'd3;
    localparam logic [2:0] REQ_CHAR   = 3'd4;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam logic [CFG_IW-1:0] CFG_FIRST_CODE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CODE_COUNT   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GLYPH_HEIGHT = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_FIXED_WIDTH  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_USE_WIDTH    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_USE_OFFSET   = 3'd5;

    localparam logic [7:0] FIRST_CODE_RST   = 8'd32;
    localparam logic [8:0] CODE_COUNT_RST   = 9'd95;
    localparam logic [4:0] GLYPH_HEIGHT_RST = 5'd16;
    localparam logic [4:0] FIXED_WIDTH_RST  = 5'd8;
    localparam logic [4:0] MAX_ROWS         = 5'd16;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_WRAP  = 4'b0100,
        S_ROWS  = 4'b1000
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       fetch;
        logic       wrap_sub;
        logic       issue;
        logic [3:0] row;
        logic       advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       char_draw;
        logic       base_high;
        logic       can_issue;
        logic [4:0] height;
    } dp_status_t;

    function automatic logic signed [11:0] sat_pos(input logic signed [12:0] v);
        logic signed [11:0] r;
        if (v > 13'sd2047)
            r = 12'sd2047;
        else
            r = v[11:0];
        return r;
    endfunction

endpackage

/* design/bitmap_font_text_renderer_core.sv */
// Bitmap font text renderer: turns character items into clipped 16-wide glyph rows.
// Input channel (in_valid / in_stall) carries one request per item: loads into the
// glyph, width and offset tables, a begin item (origin and colour) or a character.
// Loads, begin, newline and codes outside the font raise no in_stall and give no result.
// A drawn character holds in_stall through the fetch, a wrap step for each GLYPH_WORDS
// subtraction needed to bring the glyph start into range (none while start addresses
// stay below GLYPH_WORDS) and the issue of its h rows, h being the effective glyph height.
// Rows leave through out_valid / out_stall, one per cycle while out_stall is low, from the
// glyph memory port, behind the fetch and wrap steps; last_row marks the end.
// A two-stage row pipeline (memory read, output register) runs under out_stall:
// a stall freezes the output item and halts further glyph reads until it is taken.
// The next input item is accepted while the final row still waits on the output.
// Configuration writes (cfg_valid / cfg_ready, always ready) take effect at once and
// belong only in idle periods. Reset clears cursor, origin and colour, loads the
// register defaults and empties the pipeline; the font tables hold nothing until loaded.
module bitmap_font_text_renderer_core
    import bftr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int GLYPH_WORDS   = GLYPH_WORDS_DEF,
    parameter int CODE_SLOTS    = CODE_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [11:0]        table_index,
    input  logic [15:0]        table_word,
    input  logic signed [11:0] start_x,
    input  logic signed [11:0] start_y,
    input  logic [15:0]        pen_color,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] row_y,
    output logic signed [11:0] col_x,
    output logic [15:0]        row_mask,
    output logic [15:0]        out_color,
    output logic               last_row
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    bftr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bftr_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .GLYPH_WORDS   (GLYPH_WORDS),
        .CODE_SLOTS    (CODE_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .table_index (table_index),
        .table_word  (table_word),
        .start_x     (start_x),
        .start_y     (start_y),
        .pen_color   (pen_color),
        .char_code   (char_code),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_y       (row_y),
        .col_x       (col_x),
        .row_mask    (row_mask),
        .out_color   (out_color),
        .last_row    (last_row)
    );

endmodule

/* design/bftr_ctrl.sv */
module bftr_ctrl
    import bftr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [4:0] row_cnt_reg, row_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        cmd          = '0;
        cmd.row      = row_cnt_reg[3:0];
        in_stall     = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.char_draw)
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (status.base_high)
                    cmd.wrap_sub = 1'b1;
                else
                begin
                    state_next   = S_ROWS;
                    row_cnt_next = '0;
                end
            end
            S_ROWS:
            begin
                if (row_cnt_reg != status.height)
                begin
                    if (status.can_issue)
                    begin
                        cmd.issue    = 1'b1;
                        row_cnt_next = row_cnt_reg + 5'd1;
                    end
                end
                else if (status.can_issue)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

/* design/bftr_dp.sv */
module bftr_dp
    import bftr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int GLYPH_WORDS   = GLYPH_WORDS_DEF,
    parameter int CODE_SLOTS    = CODE_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic [2:0]          req_type,
    input  logic [11:0]         table_index,
    input  logic [15:0]         table_word,
    input  logic signed [11:0]  start_x,
    input  logic signed [11:0]  start_y,
    input  logic [15:0]         pen_color,
    input  logic [7:0]          char_code,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [11:0]  row_y,
    output logic signed [11:0]  col_x,
    output logic [15:0]         row_mask,
    output logic [15:0]         out_color,
    output logic                last_row
);

    localparam int GAW = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
    localparam int BW  = (GAW > 13) ? GAW : 13;
    localparam int CAW = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
    localparam logic [BW:0]   GW_LIM  = (BW + 1)'(GLYPH_WORDS);
    localparam logic [BW-1:0] GW_LAST = BW'(GLYPH_WORDS - 1);
    localparam logic [12:0]   CS_LIM  = 13'(CODE_SLOTS);
    localparam logic signed [12:0] SW_LIM = 13'(SCREEN_WIDTH);
    localparam logic signed [12:0] SH_LIM = 13'(SCREEN_HEIGHT);

    // font tables
    logic [15:0] glyph_mem  [GLYPH_WORDS];
    logic [4:0]  width_mem  [CODE_SLOTS];
    logic [11:0] offset_mem [CODE_SLOTS];
    logic [15:0] glyph_rd_reg;
    logic [4:0]  width_rd_reg;
    logic [11:0] offset_rd_reg;

    logic [7:0] first_code_reg, first_code_next;
    logic [8:0] code_count_reg, code_count_next;
    logic [4:0] glyph_height_reg, glyph_height_next;
    logic [4:0] fixed_width_reg, fixed_width_next;
    logic       use_width_reg, use_width_next;
    logic       use_offset_reg, use_offset_next;

    logic signed [11:0] origin_col_reg, origin_col_next;
    logic signed [11:0] cursor_col_reg, cursor_col_next;
    logic signed [11:0] cursor_row_reg, cursor_row_next;
    logic [15:0]        draw_color_reg, draw_color_next;

    logic [7:0]    idx_reg, idx_next;
    logic [4:0]    w_reg, w_next;
    logic [15:0]   clip_reg, clip_next;
    logic [BW-1:0] base_reg, base_next;
    logic [3:0]    s1_row_reg, s1_row_next;
    logic          s1v_reg, s1v_next;
    logic          ov_reg, ov_next;

    logic signed [11:0] row_y_reg, row_y_next;
    logic signed [11:0] col_x_reg, col_x_next;
    logic [15:0]        mask_reg, mask_next;
    logic [15:0]        color_reg, color_next;
    logic               last_reg, last_next;

    logic [4:0]    h_eff;
    logic [7:0]    idx_in;
    logic          in_font;
    logic          is_char;
    logic          is_nl;
    logic          draw_start;
    logic [BW-1:0] load_addr;
    logic          glyph_we;
    logic          width_we;
    logic          offset_we;
    logic          can2;
    logic          adv1;
    logic          load2;
    logic [4:0]    w_sel;
    logic [4:0]    wd;
    logic [15:0]   wmask;
    logic [15:0]   colmask;
    logic [12:0]   prod;
    logic signed [12:0] col13;
    logic signed [12:0] row13;
    logic signed [12:0] y13;
    logic signed [12:0] xpos [16];
    logic          vis;

    assign h_eff     = (glyph_height_reg > MAX_ROWS) ? MAX_ROWS : glyph_height_reg;
    assign idx_in    = char_code - first_code_reg;
    assign in_font   = (char_code >= first_code_reg) && ({1'b0, idx_in} < code_count_reg)
                       && ({5'b0, idx_in} < CS_LIM);
    assign is_char   = cmd.accept && (req_type == REQ_CHAR);
    assign is_nl     = is_char && (char_code == NEWLINE_CODE);
    assign draw_start = is_char && !is_nl && in_font;
    assign load_addr = BW'(table_index);
    assign glyph_we  = cmd.accept && (req_type == REQ_BITMAP)
                       && ({1'b0, load_addr} < GW_LIM);
    assign width_we  = cmd.accept && (req_type == REQ_WIDTH) && ({1'b0, table_index} < CS_LIM);
    assign offset_we = cmd.accept && (req_type == REQ_OFFSET) && ({1'b0, table_index} < CS_LIM);

    assign can2  = !ov_reg || !out_stall;
    assign adv1  = !s1v_reg || can2;
    assign load2 = s1v_reg && can2;

    assign col13 = {cursor_col_reg[11], cursor_col_reg};
    assign row13 = {cursor_row_reg[11], cursor_row_reg};
    assign y13   = row13 + 13'(s1_row_reg);
    assign vis   = !y13[12] && (y13 < SH_LIM);

    assign status.char_draw = (req_type == REQ_CHAR) && (char_code != NEWLINE_CODE) && in_font;
    assign status.base_high = ({1'b0, base_reg} >= GW_LIM);
    assign status.can_issue = adv1;
    assign status.height    = h_eff;

    assign w_sel = use_width_reg ? width_rd_reg : fixed_width_reg;
    assign wd    = (w_sel > MAX_ROWS) ? MAX_ROWS : w_sel;
    assign wmask = 16'(32'hFFFF0000 >> wd);
    assign prod  = 13'(idx_reg) * 13'(h_eff);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            xpos[i]       = col13 + 13'(i);
            colmask[15-i] = !xpos[i][12] && (xpos[i] < SW_LIM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (glyph_we)
            glyph_mem[load_addr[GAW-1:0]] <= table_word;
        if (cmd.issue)
            glyph_rd_reg <= glyph_mem[base_reg[GAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (width_we)
            width_mem[table_index[CAW-1:0]] <= table_word[4:0];
        if (offset_we)
            offset_mem[table_index[CAW-1:0]] <= table_word[11:0];
        if (draw_start)
        begin
            width_rd_reg  <= width_mem[idx_in[CAW-1:0]];
            offset_rd_reg <= offset_mem[idx_in[CAW-1:0]];
        end
    end

    // configuration
    always_comb
    begin
        first_code_next   = first_code_reg;
        code_count_next   = code_count_reg;
        glyph_height_next = glyph_height_reg;
        fixed_width_next  = fixed_width_reg;
        use_width_next    = use_width_reg;
        use_offset_next   = use_offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_CODE:   first_code_next   = cfg_data[7:0];
                CFG_CODE_COUNT:   code_count_next   = cfg_data[8:0];
                CFG_GLYPH_HEIGHT: glyph_height_next = cfg_data[4:0];
                CFG_FIXED_WIDTH:  fixed_width_next  = cfg_data[4:0];
                CFG_USE_WIDTH:    use_width_next    = cfg_data[0];
                CFG_USE_OFFSET:   use_offset_next   = cfg_data[0];
                default:          ;
            endcase
        end
    end

    // cursor and pen
    always_comb
    begin
        origin_col_next = origin_col_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        draw_color_next = draw_color_reg;
        if (cmd.accept && (req_type == REQ_BEGIN))
        begin
            origin_col_next = start_x;
            cursor_col_next = start_x;
            cursor_row_next = start_y;
            draw_color_next = pen_color;
        end
        else if (is_nl)
        begin
            cursor_col_next = origin_col_reg;
            cursor_row_next = sat_pos(row13 + 13'(h_eff));
        end
        else if (is_char && !in_font)
            cursor_col_next = sat_pos(col13 + 13'sd1);
        else if (cmd.advance)
            cursor_col_next = sat_pos(col13 + 13'(w_reg) + 13'sd1);
    end

    // glyph setup and row pipeline
    always_comb
    begin
        idx_next    = idx_reg;
        w_next      = w_reg;
        clip_next   = clip_reg;
        base_next   = base_reg;
        s1_row_next = s1_row_reg;
        if (draw_start)
            idx_next = idx_in;
        if (cmd.fetch)
        begin
            w_next    = w_sel;
            clip_next = wmask & colmask;
            base_next = use_offset_reg ? BW'(offset_rd_reg) : BW'(prod);
        end
        else if (cmd.wrap_sub)
            base_next = base_reg - GW_LIM[BW-1:0];
        else if (cmd.issue)
        begin
            base_next   = (base_reg == GW_LAST) ? '0 : base_reg + 1'b1;
            s1_row_next = cmd.row;
        end

        s1v_next = cmd.issue ? 1'b1 : (adv1 ? 1'b0 : s1v_reg);
        ov_next  = load2 || (ov_reg && out_stall);

        row_y_next = row_y_reg;
        col_x_next = col_x_reg;
        mask_next  = mask_reg;
        color_next = color_reg;
        last_next  = last_reg;
        if (load2)
        begin
            row_y_next = sat_pos(y13);
            col_x_next = cursor_col_reg;
            mask_next  = vis ? (glyph_rd_reg & clip_reg) : 16'h0000;
            color_next = draw_color_reg;
            last_next  = ({1'b0, s1_row_reg} + 5'd1 == h_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_code_reg   <= FIRST_CODE_RST;
            code_count_reg   <= CODE_COUNT_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
            fixed_width_reg  <= FIXED_WIDTH_RST;
            use_width_reg    <= 1'b0;
            use_offset_reg   <= 1'b0;
            origin_col_reg   <= '0;
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            draw_color_reg   <= '0;
            s1v_reg          <= 1'b0;
            ov_reg           <= 1'b0;
        end
        else
        begin
            first_code_reg   <= first_code_next;
            code_count_reg   <= code_count_next;
            glyph_height_reg <= glyph_height_next;
            fixed_width_reg  <= fixed_width_next;
            use_width_reg    <= use_width_next;
            use_offset_reg   <= use_offset_next;
            origin_col_reg   <= origin_col_next;
            cursor_col_reg   <= cursor_col_next;
            cursor_row_reg   <= cursor_row_next;
            draw_color_reg   <= draw_color_next;
            s1v_reg          <= s1v_next;
            ov_reg           <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        w_reg      <= w_next;
        clip_reg   <= clip_next;
        base_reg   <= base_next;
        s1_row_reg <= s1_row_next;
        row_y_reg  <= row_y_next;
        col_x_reg  <= col_x_next;
        mask_reg   <= mask_next;
        color_reg  <= color_next;
        last_reg   <= last_next;
    end

    assign out_valid = ov_reg;
    assign row_y     = row_y_reg;
    assign col_x     = col_x_reg;
    assign row_mask  = mask_reg;
    assign out_color = color_reg;
    assign last_row  = last_reg;

endmodule

/* design/bftr_checker.sv */
module bftr_props
    import bftr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [11:0] row_y,
    input logic signed [11:0] col_x,
    input logic [15:0]        row_mask,
    input logic               last_row
);

    // stalled item held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_y) && $stable(col_x)
            && $stable(row_mask) && $stable(last_row))
        else $error("stalled output item changed");

    // set pixels only on rows not above the screen
    a_row_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (row_mask != 16'h0000) |-> !row_y[11])
        else $error("pixels set on a row above the screen");

    // leftmost pixel only at a column not left of the screen
    a_col_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_mask[15] |-> !col_x[11])
        else $error("leftmost pixel set left of the screen");

    // glyph still in progress while a non-final row is shown
    a_glyph_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_row |-> in_stall)
        else $error("new item taken before the glyph finished");

endmodule

bind bitmap_font_text_renderer_core bftr_props u_bftr_props (.*);

/* dv/bftr_checker.sv */
module bftr_checker
    import bftr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [11:0]        table_index,
    input  logic [15:0]        table_word,
    input  logic signed [11:0] start_x,
    input  logic signed [11:0] start_y,
    input  logic [15:0]        pen_color,
    input  logic [7:0]         char_code,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [11:0] row_y,
    input  logic signed [11:0] col_x,
    input  logic [15:0]        row_mask,
    input  logic [15:0]        out_color,
    input  logic               last_row,
    output int                 mismatches,
    output int                 pending_rows
);

    typedef struct packed {
        logic signed [11:0] y;
        logic signed [11:0] x;
        logic [15:0]        mask;
        logic [15:0]        color;
        logic               last;
    } glyph_row_t;

    glyph_row_t  row_queue [$];

    logic [15:0] glyph_bits   [0:GLYPH_WORDS_DEF-1];
    logic [4:0]  glyph_widths [0:CODE_SLOTS_DEF-1];
    logic [11:0] glyph_starts [0:CODE_SLOTS_DEF-1];

    int          line_origin;
    int          pen_col;
    int          pen_row;
    logic [15:0] ink_color;

    logic [7:0]  code_base;
    logic [8:0]  code_span;
    logic [4:0]  rows_per_glyph;
    logic [4:0]  default_width;
    logic        width_from_table;
    logic        start_from_table;

    function automatic int clamp12(input int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    task automatic render_char(input logic [7:0] code);
        int          idx;
        int          w;
        int          wd;
        int          h;
        int          base;
        int          y;
        int          x;
        logic [31:0] wide;
        logic [15:0] wmask;
        logic [15:0] m;
        glyph_row_t  r;
        h = (rows_per_glyph > 5'd16) ? 16 : int'(rows_per_glyph);
        if (code == NEWLINE_CODE)
        begin
            pen_col = line_origin;
            pen_row = clamp12(pen_row + h);
            return;
        end
        idx = int'(code) - int'(code_base);
        if (idx < 0 || idx >= int'(code_span) || idx >= CODE_SLOTS_DEF)
        begin
            pen_col = clamp12(pen_col + 1);
            return;
        end
        w = width_from_table ? int'(glyph_widths[idx]) : int'(default_width);
        wd = (w > 16) ? 16 : w;
        wide = 32'hFFFF_0000 >> wd;
        wmask = wide[15:0];
        base = start_from_table ? int'(glyph_starts[idx]) : idx * h;
        for (int j = 0; j < h; j++)
        begin
            y = pen_row + j;
            m = glyph_bits[(base + j) % GLYPH_WORDS_DEF] & wmask;
            if (y < 0 || y >= SCREEN_HEIGHT_DEF)
                m = '0;
            else
            begin
                for (int i = 0; i < 16; i++)
                begin
                    x = pen_col + i;
                    if (x < 0 || x >= SCREEN_WIDTH_DEF)
                        m[15-i] = 1'b0;
                end
            end
            r.y     = 12'(clamp12(y));
            r.x     = 12'(pen_col);
            r.mask  = m;
            r.color = ink_color;
            r.last  = (j == h - 1);
            row_queue.push_back(r);
        end
        pen_col = clamp12(pen_col + w + 1);
    endtask

    task automatic apply_request();
        case (req_type)
            REQ_BITMAP:
                glyph_bits[table_index] = table_word;
            REQ_WIDTH:
                if (table_index < CODE_SLOTS_DEF)
                    glyph_widths[table_index[7:0]] = table_word[4:0];
            REQ_OFFSET:
                if (table_index < CODE_SLOTS_DEF)
                    glyph_starts[table_index[7:0]] = table_word[11:0];
            REQ_BEGIN:
            begin
                line_origin = int'(start_x);
                pen_col     = int'(start_x);
                pen_row     = int'(start_y);
                ink_color   = pen_color;
            end
            REQ_CHAR:
                render_char(char_code);
            default:
                ;
        endcase
    endtask

    task automatic check_row();
        glyph_row_t got;
        glyph_row_t want;
        got = {row_y, col_x, row_mask, out_color, last_row};
        if (row_queue.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected row: y=%0d x=%0d mask=%h color=%h last=%b",
                         got.y, got.x, got.mask, got.color, got.last);
            mismatches++;
        end
        else
        begin
            want = row_queue.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("row mismatch: want y=%0d x=%0d mask=%h color=%h last=%b,",
                             want.y, want.x, want.mask, want.color, want.last,
                             " got y=%0d x=%0d mask=%h color=%h last=%b",
                             got.y, got.x, got.mask, got.color, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_queue.delete();
            line_origin      = 0;
            pen_col          = 0;
            pen_row          = 0;
            ink_color        = '0;
            code_base        = FIRST_CODE_RST;
            code_span        = CODE_COUNT_RST;
            rows_per_glyph   = GLYPH_HEIGHT_RST;
            default_width    = FIXED_WIDTH_RST;
            width_from_table = 1'b0;
            start_from_table = 1'b0;
            mismatches       = 0;
            pending_rows     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIRST_CODE:   code_base        = cfg_data[7:0];
                    CFG_CODE_COUNT:   code_span        = cfg_data[8:0];
                    CFG_GLYPH_HEIGHT: rows_per_glyph   = cfg_data[4:0];
                    CFG_FIXED_WIDTH:  default_width    = cfg_data[4:0];
                    CFG_USE_WIDTH:    width_from_table = cfg_data[0];
                    CFG_USE_OFFSET:   start_from_table = cfg_data[0];
                    default:          ;
                endcase
            end
            if (out_valid && !out_stall)
                check_row();
            if (in_valid && !in_stall)
                apply_request();
            pending_rows = row_queue.size();
        end
    end

endmodule

/* dv/tb_bitmap_font_text_renderer_core.sv */
module tb_bitmap_font_text_renderer_core;
    import bftr_pkg::*;

    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_COUNT    = 170;
    localparam int PHASE_ITEMS   = 24;

    localparam logic [2:0]        REQ_SPARE_LO = 3'd5;
    localparam logic [2:0]        REQ_SPARE_HI = 3'd7;
    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_IW-1:0]  cfg_index;
    logic [CFG_DW-1:0]  cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         req_type;
    logic [11:0]        table_index;
    logic [15:0]        table_word;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic [15:0]        pen_color;
    logic [7:0]         char_code;
    logic               out_valid;
    logic               out_stall;
    logic signed [11:0] row_y;
    logic signed [11:0] col_x;
    logic [15:0]        row_mask;
    logic [15:0]        out_color;
    logic               last_row;

    int mismatches;
    int pending_rows;
    int cycle_count = 0;
    int items_sent  = 0;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    // what the stimulus has already loaded, so no glyph reads an empty entry
    bit          bits_seen   [0:GLYPH_WORDS_DEF-1];
    bit          width_seen  [0:CODE_SLOTS_DEF-1];
    bit          start_seen  [0:CODE_SLOTS_DEF-1];
    logic [11:0] start_value [0:CODE_SLOTS_DEF-1];

    int sh_first;
    int sh_count;
    int sh_height;
    int sh_use_offset;

    bitmap_font_text_renderer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .table_index (table_index),
        .table_word  (table_word),
        .start_x     (start_x),
        .start_y     (start_y),
        .pen_color   (pen_color),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_y       (row_y),
        .col_x       (col_x),
        .row_mask    (row_mask),
        .out_color   (out_color),
        .last_row    (last_row)
    );

    bftr_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .table_index  (table_index),
        .table_word   (table_word),
        .start_x      (start_x),
        .start_y      (start_y),
        .pen_color    (pen_color),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_y        (row_y),
        .col_x        (col_x),
        .row_mask     (row_mask),
        .out_color    (out_color),
        .last_row     (last_row),
        .mismatches   (mismatches),
        .pending_rows (pending_rows)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver side: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(2, 0) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(16, 1)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet)
                repeat ($urandom_range(30, 0)) @(posedge clk);
        end
    end

    function automatic logic [11:0] pick_pos(input int limit);
        int v;
        case ($urandom_range(5, 0))
            0:       v = 2047 - int'($urandom_range(20, 0));
            1:       v = -2048 + int'($urandom_range(20, 0));
            2:       v = int'($urandom_range(40, 0)) - 20;
            3:       v = limit - 20 + int'($urandom_range(40, 0));
            4:       v = int'($urandom);
            default: v = int'($urandom_range(limit - 1, 0));
        endcase
        return v[11:0];
    endfunction

    function automatic logic [15:0] pick_start();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(3, 0))
            0:       w[11:0] = 12'hFF0 | 12'($urandom_range(15, 0));
            1:       ;
            default: w[11:0] = 12'($urandom_range(511, 0));
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pick_code();
        int r;
        int lo;
        int hi;
        r = int'($urandom_range(15, 0));
        lo = sh_first;
        hi = sh_first + sh_count - 1;
        if (hi > 255)
            hi = 255;
        if (r == 0)
            return NEWLINE_CODE;
        if (r == 1 || sh_count == 0)
            return 8'($urandom);
        if (r < 12 && hi > lo + 11)
            hi = lo + 11;
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val, input int bits);
        logic [CFG_DW-1:0] keep;
        logic [CFG_DW-1:0] data;
        keep = CFG_DW'((1 << bits) - 1);
        data = CFG_DW'($urandom);
        data = (data & ~keep) | (val[CFG_DW-1:0] & keep);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_config(input int fc, input int cc, input int gh,
                                input int fw, input int uw, input int uo);
        write_reg(CFG_FIRST_CODE, fc, 8);
        write_reg(CFG_CODE_COUNT, cc, 9);
        write_reg(CFG_GLYPH_HEIGHT, gh, 5);
        write_reg(CFG_FIXED_WIDTH, fw, 5);
        write_reg(CFG_USE_WIDTH, uw, 1);
        write_reg(CFG_USE_OFFSET, uo, 1);
        cfg_valid <= 1'b0;
        sh_first      = fc;
        sh_count      = cc;
        sh_height     = gh;
        sh_use_offset = uo;
    endtask

    task automatic wait_idle();
        int calm;
        calm = 0;
        in_valid <= 1'b0;
        while (calm < SETTLE_CYCLES)
        begin
            @(posedge clk);
            if (pending_rows != 0)
                calm = 0;
            else
                calm++;
        end
    endtask

    task automatic push_item(input logic [2:0] t, input logic [11:0] idx,
                             input logic [15:0] word, input logic [11:0] sx,
                             input logic [11:0] sy, input logic [15:0] color,
                             input logic [7:0] code);
        if (items_sent >= ITEM_COUNT - 35)
            quiet = 1'b1;
        if (!quiet && $urandom_range(5, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= t;
        table_index <= idx;
        table_word  <= word;
        start_x     <= sx;
        start_y     <= sy;
        pen_color   <= color;
        char_code   <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (t == REQ_BITMAP)
            bits_seen[idx] = 1'b1;
        else if (t == REQ_WIDTH && idx < CODE_SLOTS_DEF)
            width_seen[idx[7:0]] = 1'b1;
        else if (t == REQ_OFFSET && idx < CODE_SLOTS_DEF)
        begin
            start_seen[idx[7:0]]  = 1'b1;
            start_value[idx[7:0]] = word[11:0];
        end
    endtask

    task automatic send_load(input logic [2:0] t, input int idx, input logic [15:0] word);
        push_item(t, idx[11:0], word, 12'($urandom), 12'($urandom), 16'($urandom),
                  8'($urandom));
    endtask

    task automatic send_begin(input logic [11:0] sx, input logic [11:0] sy,
                              input logic [15:0] color);
        push_item(REQ_BEGIN, 12'($urandom), 16'($urandom), sx, sy, color, 8'($urandom));
    endtask

    task automatic send_noise();
        push_item(3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)), 12'($urandom),
                  16'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
                  8'($urandom));
    endtask

    task automatic send_random_load();
        logic [2:0]  t;
        logic [11:0] idx;
        t = 3'($urandom_range(REQ_OFFSET, REQ_BITMAP));
        idx = 12'($urandom);
        if (t != REQ_BITMAP && $urandom_range(1, 0) == 0)
            idx[11:8] = 4'h0;
        send_load(t, int'(idx), 16'($urandom));
    endtask

    // loads whatever the glyph still lacks, then offers the character
    task automatic send_char(input logic [7:0] code);
        int idx;
        int hh;
        int base;
        int addr;
        if (code != NEWLINE_CODE && int'(code) >= sh_first && int'(code) - sh_first < sh_count)
        begin
            idx = int'(code) - sh_first;
            hh = (sh_height > 16) ? 16 : sh_height;
            if (!width_seen[idx])
                send_load(REQ_WIDTH, idx, 16'($urandom));
            if (!start_seen[idx])
                send_load(REQ_OFFSET, idx, pick_start());
            base = sh_use_offset ? int'(start_value[idx]) : idx * hh;
            for (int j = 0; j < hh; j++)
            begin
                addr = (base + j) % GLYPH_WORDS_DEF;
                if (!bits_seen[addr])
                    send_load(REQ_BITMAP, addr, 16'($urandom));
            end
        end
        push_item(REQ_CHAR, 12'($urandom), 16'($urandom), 12'($urandom), 12'($urandom),
                  16'($urandom), code);
    endtask

    initial
    begin
        int phase;
        int phase_end;
        int r;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = '0;
        table_index = '0;
        table_word  = '0;
        start_x     = '0;
        start_y     = '0;
        pen_color   = '0;
        char_code   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_SPARE_LO, 0, 0);
        write_reg(CFG_SPARE_HI, 0, 0);
        apply_config(32, 95, 3, 8, 0, 0);

        // directed: full bits, clipping on every edge, saturation, ignored items
        send_begin(12'd0, 12'd0, 16'hFFFF);
        send_char("A");
        send_char("A");
        send_char(NEWLINE_CODE);
        send_char(8'd31);
        send_char(8'd127);
        send_char(8'd255);
        push_item(REQ_SPARE_HI, '1, '1, '1, '1, '1, '1);
        push_item(REQ_SPARE_LO, '0, '0, '0, '0, '0, '0);
        send_load(REQ_WIDTH, 4095, 16'hFFFF);
        send_load(REQ_OFFSET, 256, 16'hFFFF);
        send_begin(-12'sd8, -12'sd1, 16'h0000);
        send_char("A");
        send_begin(12'd470, 12'd318, 16'hA5A5);
        send_char("A");
        send_begin(12'sd2047, 12'sd2047, 16'h5A5A);
        send_char("A");
        send_char(NEWLINE_CODE);
        send_begin(-12'sd2048, -12'sd2048, 16'h1234);
        send_char("A");

        phase = 0;
        while (items_sent < ITEM_COUNT)
        begin
            wait_idle();
            case (phase)
                0:       apply_config(0, 256, 16, 16, 0, 0);
                1:       apply_config(200, 256, 31, 31, 1, 1);
                2:       apply_config(255, 1, 0, 5, 1, 0);
                3:       apply_config(65, 0, 1, 0, 0, 1);
                default: apply_config($urandom_range(255, 0),
                                      ($urandom_range(3, 0) == 0) ? $urandom_range(256, 0)
                                                                  : $urandom_range(40, 1),
                                      ($urandom_range(3, 0) == 0) ? $urandom_range(31, 0)
                                                                  : $urandom_range(16, 1),
                                      $urandom_range(31, 0), $urandom_range(1, 0),
                                      $urandom_range(1, 0));
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            send_begin(pick_pos(SCREEN_WIDTH_DEF), pick_pos(SCREEN_HEIGHT_DEF),
                       16'($urandom));
            if (phase == 0)
                hold_req = 1'b1;
            while (items_sent < phase_end && items_sent < ITEM_COUNT)
            begin
                r = (phase == 0) ? 19 : int'($urandom_range(19, 0));
                if (r == 0)
                    send_noise();
                else if (r == 1)
                    send_random_load();
                else if (r < 4)
                    send_begin(pick_pos(SCREEN_WIDTH_DEF), pick_pos(SCREEN_HEIGHT_DEF),
                               16'($urandom));
                else
                    send_char(pick_code());
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && pending_rows == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/bftr_pkg.sv
design/bftr_ctrl.sv
design/bftr_dp.sv
design/bitmap_font_text_renderer_core.sv
design/bftr_checker.sv
dv/bftr_checker.sv
dv/tb_bitmap_font_text_renderer_core.sv
